/* src/pses_pkg.sv */
// Package for the PSG sound-effect sequencer: command codes, step entry layout,
// register map and the sound-generator byte constants.
// No dependencies; imported by psg_sound_effect_sequencer.
package pses_pkg;

  // Command codes carried in the input tuser field.
  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_PLAY      = 3'd1,
    CMD_INIT      = 3'd2,
    CMD_LOAD      = 3'd3,
    CMD_SET_START = 3'd4
  } cmd_t;

  // One step entry as held in the step memory (51 bits).
  typedef struct packed {
    logic [15:0] tone;
    logic [15:0] slide;
    logic [3:0]  tone_vol;
    logic [2:0]  noise_mode;
    logic [3:0]  noise_vol;
    logic [7:0]  frames;
  } step_t;

  // Byte sequence for the tone channel: one mute byte or three setting bytes.
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b2;
    logic [7:0] b1;
    logic [7:0] b0;
  } tone_seq_t;

  // Byte sequence for the noise channel: one mute byte or two setting bytes.
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b1;
    logic [7:0] b0;
  } noise_seq_t;

  // Register map.
  localparam logic REG_EFFECT_COUNT = 1'b0;
  localparam logic [4:0] EFFECT_COUNT_RESET = 5'd12;

  // Tone period limit of the sound generator.
  localparam logic [9:0] MAX_PERIOD = 10'd1023;

  // Sound-generator register bytes.
  localparam logic [7:0] BYTE_CH0_MUTE   = 8'h9F;
  localparam logic [7:0] BYTE_CH1_MUTE   = 8'hBF;
  localparam logic [7:0] BYTE_TONE_MUTE  = 8'hDF;
  localparam logic [7:0] BYTE_NOISE_MUTE = 8'hFF;
  localparam logic [7:0] BYTE_TONE_LATCH = 8'hC0;
  localparam logic [7:0] BYTE_TONE_VOL   = 8'hD0;
  localparam logic [7:0] BYTE_NOISE_CTRL = 8'hE0;
  localparam logic [7:0] BYTE_NOISE_VOL  = 8'hF0;
  localparam logic [7:0] MASK_LOW_NIBBLE = 8'h0F;
  localparam logic [7:0] MASK_HIGH_BITS  = 8'h3F;
  localparam logic [7:0] MASK_NOISE_MODE = 8'h07;

  localparam logic [3:0] VOL_MUTED = 4'd15;

endpackage

/* src/psg_sound_effect_sequencer.sv */
// Top level of the PSG sound-effect sequencer: command decode, step and start
// memories, effect playback state and the output byte buffer.
// Depends on pses_pkg.
//
//  Channel   Kind          Payload
//  s_*       stream in     tuser: command; tdata: effect id, step fields
//  m_*       stream out    tdata: psg_byte; tlast: final byte of the command
//  p*        APB register  effect_count at byte address 0
//
// Each accepted command waits in the command register and executes once the
// output buffer can take its bytes. A command emits at most five bytes, drained
// one per cycle while m_tready is high, and silent commands flow at one per
// cycle. Reset clears the playback state and the buffers; memory contents are
// undefined until loaded. A stalled output holds its byte and stalls the input
// only once the waiting command needs it.
module psg_sound_effect_sequencer #(
  parameter int STEP_DEPTH   = 64,
  parameter int EFFECT_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata, low bit first: effect_id[3:0], entry_index[9:4], entry_tone[25:10],
  // entry_slide[41:26], entry_tone_vol[45:42], entry_noise_mode[48:46],
  // entry_noise_vol[52:49], entry_frames[60:53], zero fill[63:61].
  input  logic [63:0] s_tdata,
  // tuser: command[2:0].
  input  logic [2:0]  s_tuser,
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: psg_byte[7:0].
  output logic [7:0]  m_tdata,
  output logic        m_tlast,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import pses_pkg::*;

  localparam int SW = $clog2(STEP_DEPTH);
  localparam int EW = (EFFECT_SLOTS > 1) ? $clog2(EFFECT_SLOTS) : 1;
  localparam logic [SW-1:0] LAST_SLOT  = SW'(STEP_DEPTH - 1);
  localparam logic [10:0]   DEPTH_LIM  = 11'(STEP_DEPTH);
  localparam logic [8:0]    SLOTS_LIM  = 9'(EFFECT_SLOTS);
  localparam logic [16:0]   DEPTH_WIDE = 17'(STEP_DEPTH);

  // Configuration register.
  logic [4:0] effect_count;

  // Command register: the transfer waiting to execute.
  logic        item_valid;
  cmd_t        item_cmd;
  logic [3:0]  item_id;
  logic [5:0]  item_index;
  step_t       item_step;

  // Playback state.
  logic          playing, playing_next;
  logic [SW-1:0] step_pointer, step_pointer_next;
  logic [7:0]    frames_left, frames_left_next;
  logic [15:0]   current_period, current_period_next;
  logic [15:0]   current_slide, current_slide_next;

  // Memories and their registered read data.
  step_t         step_mem [STEP_DEPTH];
  logic [SW-1:0] start_mem [EFFECT_SLOTS];
  step_t         step_rd;
  logic [SW-1:0] start_rd;

  // Output byte buffer; entry 0 is the byte on the port.
  logic [7:0] obuf [5];
  logic [2:0] ob_cnt;

  // Execute-stage signals.
  logic          exec;
  logic          buf_free;
  logic          accept;
  logic          step_we, start_we;
  logic          step_wr, start_wr;
  logic [SW-1:0] step_waddr, rd_addr, ptr_inc;
  logic [EW-1:0] start_waddr, start_raddr;
  logic [SW-1:0] start_wdata;
  logic [2:0]    nb;
  logic [7:0]    bytes [5];
  logic          use_tone, use_noise, fixed_init;
  logic [15:0]   tone_p;
  logic [3:0]    tone_v, noise_v;
  logic [2:0]    noise_m;
  tone_seq_t     tseq;
  noise_seq_t    nseq;
  logic [17:0]   slide_sum;
  logic [15:0]   slid_period;
  logic [7:0]    frames_base;
  logic          count_down;

  // Start slot of a set-start command, reduced modulo the step depth.
  function automatic logic [SW-1:0] slot_mod(input logic [5:0] v);
    logic [16:0] r;
    r = 17'(v);
    for (int k = 5; k >= 0; k--) begin
      if (r >= (DEPTH_WIDE << k)) begin
        r = r - (DEPTH_WIDE << k);
      end
    end
    return SW'(r);
  endfunction

  // Tone channel bytes; a zero period or full attenuation mutes the channel.
  function automatic tone_seq_t tone_bytes(input logic [15:0] p, input logic [3:0] v);
    tone_seq_t  t;
    logic [9:0] pc;
    pc = (p > 16'(MAX_PERIOD)) ? MAX_PERIOD : p[9:0];
    t.b0  = BYTE_TONE_LATCH | ({4'b0, pc[3:0]} & MASK_LOW_NIBBLE);
    t.b1  = {2'b0, pc[9:4]} & MASK_HIGH_BITS;
    t.b2  = BYTE_TONE_VOL | {4'b0, v};
    t.cnt = 2'd3;
    if (p == 16'd0 || v == VOL_MUTED) begin
      t.b0  = BYTE_TONE_MUTE;
      t.cnt = 2'd1;
    end
    return t;
  endfunction

  // Noise channel bytes; mode zero or full attenuation mutes the channel.
  function automatic noise_seq_t noise_bytes(input logic [2:0] m, input logic [3:0] v);
    noise_seq_t n;
    n.b0  = BYTE_NOISE_CTRL | ({5'b0, m} & MASK_NOISE_MODE);
    n.b1  = BYTE_NOISE_VOL | {4'b0, v};
    n.cnt = 2'd2;
    if (m == 3'd0 || v == VOL_MUTED) begin
      n.b0  = BYTE_NOISE_MUTE;
      n.cnt = 2'd1;
    end
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration port. Writes land on the access cycle; pready is tied high.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      effect_count <= EFFECT_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_EFFECT_COUNT) begin
      effect_count <= pwdata[4:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_EFFECT_COUNT) begin
      prdata = {27'd0, effect_count};
    end
  end

  // ---------------------------------------------------------------------------
  // Command register. It refills in the cycle its current command executes.
  // ---------------------------------------------------------------------------
  assign s_tready = !item_valid || exec;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_cmd             <= cmd_t'(s_tuser);
      item_id              <= s_tdata[3:0];
      item_index           <= s_tdata[9:4];
      item_step.tone       <= s_tdata[25:10];
      item_step.slide      <= s_tdata[41:26];
      item_step.tone_vol   <= s_tdata[45:42];
      item_step.noise_mode <= s_tdata[48:46];
      item_step.noise_vol  <= s_tdata[52:49];
      item_step.frames     <= s_tdata[60:53];
    end
  end

  // ---------------------------------------------------------------------------
  // Memories. The step memory is read every cycle at the pointer that will be
  // current next cycle, so step_rd always mirrors the entry under the pointer.
  // A write to that same entry in the same cycle is passed straight through.
  // The start memory is read when a command is taken, at its effect id.
  // ---------------------------------------------------------------------------
  assign step_waddr  = SW'(item_index);
  assign start_waddr = EW'(item_id);
  assign start_wdata = slot_mod(item_index);
  assign start_raddr = EW'(s_tdata[3:0]);
  assign rd_addr     = exec ? step_pointer_next : step_pointer;

  // Memory writes only happen when the command actually executes.
  assign step_wr  = step_we && exec;
  assign start_wr = start_we && exec;

  always_ff @(posedge clk) begin
    if (step_wr) begin
      step_mem[step_waddr] <= item_step;
    end
    if (step_wr && step_waddr == rd_addr) begin
      step_rd <= item_step;
    end else begin
      step_rd <= step_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (start_wr) begin
      start_mem[start_waddr] <= start_wdata;
    end
    if (accept) begin
      if (start_wr && start_waddr == start_raddr) begin
        start_rd <= start_wdata;
      end else begin
        start_rd <= start_mem[start_raddr];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Execute stage: decode the command, update playback state, build bytes.
  // ---------------------------------------------------------------------------
  assign ptr_inc   = (step_pointer == LAST_SLOT) ? '0 : step_pointer + 1'b1;
  assign slide_sum = $signed({2'b00, current_period})
                   + $signed({{2{current_slide[15]}}, current_slide});

  always_comb begin
    if ($signed(slide_sum) < 18'sd1) begin
      slid_period = 16'd1;
    end else if ($signed(slide_sum) > $signed({8'd0, MAX_PERIOD})) begin
      slid_period = 16'(MAX_PERIOD);
    end else begin
      slid_period = slide_sum[15:0];
    end
  end

  always_comb begin
    playing_next        = playing;
    step_pointer_next   = step_pointer;
    frames_left_next    = frames_left;
    current_period_next = current_period;
    current_slide_next  = current_slide;
    step_we             = 1'b0;
    start_we            = 1'b0;
    use_tone            = 1'b0;
    use_noise           = 1'b0;
    fixed_init          = 1'b0;
    tone_p              = 16'd0;
    tone_v              = VOL_MUTED;
    noise_m             = 3'd0;
    noise_v             = VOL_MUTED;
    frames_base         = frames_left;
    count_down          = 1'b0;

    if (item_valid) begin
      case (item_cmd)
        CMD_TICK: begin
          if (playing) begin
            if (frames_left == 8'd0) begin
              if (step_rd.frames == 8'd0) begin
                // End of the effect: mute both channels and stop.
                playing_next = 1'b0;
                use_tone     = 1'b1;
                use_noise    = 1'b1;
              end else begin
                current_period_next = step_rd.tone;
                current_slide_next  = step_rd.slide;
                frames_base         = step_rd.frames;
                count_down          = 1'b1;
                use_tone            = 1'b1;
                use_noise           = 1'b1;
                tone_p              = step_rd.tone;
                tone_v              = step_rd.tone_vol;
                noise_m             = step_rd.noise_mode;
                noise_v             = step_rd.noise_vol;
              end
            end else begin
              count_down = 1'b1;
              if (current_slide != 16'd0 && current_period != 16'd0) begin
                current_period_next = slid_period;
                use_tone            = 1'b1;
                tone_p              = slid_period;
                tone_v              = step_rd.tone_vol;
              end
            end
          end
        end
        CMD_PLAY: begin
          if ({1'b0, item_id} < effect_count && {5'd0, item_id} < SLOTS_LIM) begin
            step_pointer_next = start_rd;
            frames_left_next  = 8'd0;
            playing_next      = 1'b1;
          end
        end
        CMD_INIT: begin
          playing_next = 1'b0;
          fixed_init   = 1'b1;
        end
        CMD_LOAD: begin
          step_we = ({5'd0, item_index} < DEPTH_LIM);
        end
        CMD_SET_START: begin
          start_we = ({5'd0, item_id} < SLOTS_LIM);
        end
        default: begin
        end
      endcase
    end

    if (count_down) begin
      frames_left_next = frames_base - 8'd1;
      if (frames_left_next == 8'd0) begin
        step_pointer_next = ptr_inc;
      end
    end
  end

  // Assemble the byte list: tone bytes first, then noise bytes, or the four init mute bytes.
  always_comb begin
    tseq = tone_bytes(tone_p, tone_v);
    nseq = noise_bytes(noise_m, noise_v);
    for (int i = 0; i < 5; i++) begin
      bytes[i] = 8'd0;
    end
    nb = 3'd0;
    if (fixed_init) begin
      bytes[0] = BYTE_CH0_MUTE;
      bytes[1] = BYTE_CH1_MUTE;
      bytes[2] = BYTE_TONE_MUTE;
      bytes[3] = BYTE_NOISE_MUTE;
      nb       = 3'd4;
    end else if (use_tone) begin
      bytes[0] = tseq.b0;
      if (tseq.cnt == 2'd1) begin
        bytes[1] = nseq.b0;
        bytes[2] = nseq.b1;
      end else begin
        bytes[1] = tseq.b1;
        bytes[2] = tseq.b2;
        bytes[3] = nseq.b0;
        bytes[4] = nseq.b1;
      end
      nb = {1'b0, tseq.cnt} + (use_noise ? {1'b0, nseq.cnt} : 3'd0);
    end
  end

  // A command that emits bytes waits until the buffer empties or is emptying.
  assign buf_free = (ob_cnt == 3'd0) || (ob_cnt == 3'd1 && m_tready);
  assign exec     = item_valid && (nb == 3'd0 || buf_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      playing        <= 1'b0;
      step_pointer   <= '0;
      frames_left    <= 8'd0;
      current_period <= 16'd0;
      current_slide  <= 16'd0;
    end else if (exec) begin
      playing        <= playing_next;
      step_pointer   <= step_pointer_next;
      frames_left    <= frames_left_next;
      current_period <= current_period_next;
      current_slide  <= current_slide_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output buffer: loads a whole byte list, then shifts one byte per transfer.
  // ---------------------------------------------------------------------------
  assign m_tvalid = (ob_cnt != 3'd0);
  assign m_tdata  = obuf[0];
  assign m_tlast  = (ob_cnt == 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_cnt <= 3'd0;
    end else if (exec && nb != 3'd0) begin
      ob_cnt <= nb;
    end else if (m_tvalid && m_tready) begin
      ob_cnt <= ob_cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (exec && nb != 3'd0) begin
      for (int i = 0; i < 5; i++) begin
        obuf[i] <= bytes[i];
      end
    end else if (m_tvalid && m_tready) begin
      for (int i = 0; i < 4; i++) begin
        obuf[i] <= obuf[i + 1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_buf_bound: assert property (@(posedge clk) disable iff (rst)
    ob_cnt <= 3'd5)
    else $error("output buffer count out of range");

  a_init_silences: assert property (@(posedge clk) disable iff (rst)
    (exec && item_cmd == CMD_INIT) |=> (!playing && ob_cnt == 3'd4))
    else $error("init command did not stop playback with four bytes");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    step_pointer <= LAST_SLOT)
    else $error("step pointer beyond step memory");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (exec && nb != 3'd0) |-> (ob_cnt == 3'd0 || (ob_cnt == 3'd1 && m_tready)))
    else $error("byte list loaded over undelivered bytes");

endmodule
